FILE: rtl/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg: shared constants and types for the Collatz memo cache
// Field widths, register indexes, policy codes and the control/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmc_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEFAULT    = 16;
   localparam int COUNT_WIDTH_DEFAULT = 12;

   // Fixed field widths
   localparam int KEY_WIDTH    = 31;
   localparam int AGE_WIDTH    = 32;
   localparam int LFSR_WIDTH   = 16;
   localparam int POLICY_WIDTH = 2;
   localparam int WAYS_WIDTH   = 5;
   localparam int CALC_WIDTH   = 64;

   localparam logic [LFSR_WIDTH-1:0] LFSR_SEED  = 16'hACE1;
   localparam logic [WAYS_WIDTH-1:0] WAYS_RESET = 5'd16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = WAYS_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POLICY = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WAYS   = 1'd1;

   // Replacement policies
   localparam logic [POLICY_WIDTH-1:0] POLICY_LRU    = 2'd0;
   localparam logic [POLICY_WIDTH-1:0] POLICY_RANDOM = 2'd1;
   localparam logic [POLICY_WIDTH-1:0] POLICY_SLOT0  = 2'd2;

   // Result source select
   localparam int RES_SRC_WIDTH = 2;
   localparam logic [RES_SRC_WIDTH-1:0] RES_HIT  = 2'd0;
   localparam logic [RES_SRC_WIDTH-1:0] RES_CALC = 2'd1;
   localparam logic [RES_SRC_WIDTH-1:0] RES_ZERO = 2'd2;

   // Controller -> datapath commands
   typedef struct packed {
      logic                     load_req;
      logic                     idx_clear;
      logic                     idx_inc;
      logic                     age_write;
      logic                     calc_start;
      logic                     calc_step;
      logic                     fill_slot;
      logic                     lru_cmp;
      logic                     lfsr_step;
      logic                     div_start;
      logic                     div_step;
      logic                     div_take;
      logic                     slot_zero;
      logic                     entry_write;
      logic                     res_load;
      logic [RES_SRC_WIDTH-1:0] res_src;
      logic                     out_load;
   } cmc_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic                    req_key_zero;
      logic                    filled_zero;
      logic                    key_match;
      logic                    search_last;
      logic                    calc_done;
      logic                    calc_sat;
      logic                    has_free;
      logic [POLICY_WIDTH-1:0] policy;
      logic                    lru_last;
      logic                    div_done;
      logic                    out_free;
   } cmc_status_type;

endpackage

FILE: rtl/cmc_ifs.sv
// ----------------------------------------------------------------------------
// cmc_ifs: request and response channels
// Valid/ready channels carrying the start value in and the step count out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmc_req_if;
   import cmc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KEY_WIDTH-1:0] start_value;

   modport source (output valid, output start_value, input ready);
   modport sink   (input valid, input start_value, output ready);
endinterface

interface cmc_rsp_if #(
   parameter int COUNT_WIDTH = cmc_pkg::COUNT_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] step_count;
   logic                   was_hit;
   logic                   count_saturated;

   modport source (output valid, output step_count, output was_hit,
                   output count_saturated, input ready);
   modport sink   (input valid, input step_count, input was_hit,
                   input count_saturated, output ready);
endinterface

FILE: rtl/cmc_datapath.sv
// ----------------------------------------------------------------------------
// cmc_datapath: cache storage, Collatz unit, victim logic and output register
// Executes one command bundle per cycle and reports status to the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmc_datapath #(
   parameter int CAPACITY    = cmc_pkg::CAPACITY_DEFAULT,
   parameter int COUNT_WIDTH = cmc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmc_pkg::cmc_cmd_type                cmd,
   output cmc_pkg::cmc_status_type             status,
   input  logic [cmc_pkg::KEY_WIDTH-1:0]       req_start_value,
   input  logic                                csr_write_en,
   input  logic [cmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cmc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [COUNT_WIDTH-1:0]              rsp_step_count,
   output logic                                rsp_was_hit,
   output logic                                rsp_count_saturated
);
   import cmc_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > WAYS_WIDTH) ? FILL_W : WAYS_WIDTH;
   localparam int REM_W  = CMP_W + 1;
   localparam int DCNT_W = $clog2(LFSR_WIDTH + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Storage
   logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
   logic [COUNT_WIDTH-1:0] count_mem [CAPACITY];
   logic [AGE_WIDTH-1:0]   age_mem   [CAPACITY];

   logic [KEY_WIDTH-1:0]    rd_key_ff;
   logic [COUNT_WIDTH-1:0]  rd_count_ff;
   logic [AGE_WIDTH-1:0]    rd_age_ff;

   logic [POLICY_WIDTH-1:0] policy_ff;
   logic [WAYS_WIDTH-1:0]   ways_ff;
   logic [FILL_W-1:0]       filled_ff;
   logic [AGE_WIDTH-1:0]    clock_ff;
   logic [LFSR_WIDTH-1:0]   lfsr_ff;

   logic [KEY_WIDTH-1:0]    key_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [IDX_W-1:0]        victim_ff;
   logic [AGE_WIDTH-1:0]    oldest_ff;

   logic [CALC_WIDTH-1:0]   n_ff;
   logic [COUNT_WIDTH-1:0]  steps_ff;
   logic                    sat_ff;
   logic                    calc_done_ff;

   logic [LFSR_WIDTH-1:0]   div_q_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [DCNT_W-1:0]       div_cnt_ff;

   logic [COUNT_WIDTH-1:0]  res_count_ff;
   logic                    res_hit_ff;
   logic                    res_sat_ff;

   logic                    rsp_valid_ff;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_sat_ff;

   logic [CMP_W-1:0]        ways_raw_x;
   logic [CMP_W-1:0]        ways_eff_x;
   logic [FILL_W-1:0]       ways_eff;
   logic [FILL_W-1:0]       idx_next;
   logic [CALC_WIDTH+1:0]   triple_sum;
   logic                    triple_ovf;
   logic [REM_W-1:0]        rem_shift;
   logic [IDX_W-1:0]        age_addr;
   logic                    lfsr_fb;

   // Clamp the configured way count into 1..CAPACITY
   assign ways_raw_x = CMP_W'(ways_ff);
   assign ways_eff_x = (ways_ff == '0) ? CMP_W'(1) :
                       (ways_raw_x > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : ways_raw_x;
   assign ways_eff   = FILL_W'(ways_eff_x);
   assign idx_next   = FILL_W'(idx_ff) + FILL_W'(1);

   // 3n+1 with two guard bits for overflow detection
   assign triple_sum = {1'b0, n_ff, 1'b1} + {2'b00, n_ff};
   assign triple_ovf = (triple_sum[CALC_WIDTH+1:CALC_WIDTH] != 2'b00);

   assign rem_shift = {rem_ff[REM_W-2:0], div_q_ff[LFSR_WIDTH-1]};
   assign lfsr_fb   = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
   assign age_addr  = cmd.entry_write ? victim_ff : idx_ff;

   always_comb begin
      status.req_key_zero = (req_start_value == '0);
      status.filled_zero  = (filled_ff == '0);
      status.key_match    = (rd_key_ff == key_ff);
      status.search_last  = (idx_next == filled_ff);
      status.calc_done    = calc_done_ff;
      status.calc_sat     = sat_ff;
      status.has_free     = (filled_ff < ways_eff);
      status.policy       = policy_ff;
      status.lru_last     = (idx_next == ways_eff);
      status.div_done     = (div_cnt_ff == DCNT_W'(LFSR_WIDTH));
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Configuration and persistent cache bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_LRU;
         ways_ff   <= WAYS_RESET;
         filled_ff <= '0;
         clock_ff  <= '0;
         lfsr_ff   <= LFSR_SEED;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               REG_POLICY: policy_ff <= csr_wdata[POLICY_WIDTH-1:0];
               REG_WAYS:   ways_ff   <= csr_wdata[WAYS_WIDTH-1:0];
               default:    ;
            endcase
         end
         if (cmd.load_req && (req_start_value != '0)) begin
            clock_ff <= clock_ff + AGE_WIDTH'(1);
         end
         if (cmd.fill_slot) begin
            filled_ff <= filled_ff + FILL_W'(1);
         end
         if (cmd.lfsr_step) begin
            lfsr_ff <= {lfsr_fb, lfsr_ff[LFSR_WIDTH-1:1]};
         end
      end
   end

   // Cache RAMs: write at victim, age also at walk index; registered walk read
   always_ff @(posedge clock) begin
      if (cmd.entry_write) begin
         key_mem[victim_ff]   <= key_ff;
         count_mem[victim_ff] <= steps_ff;
      end
      if (cmd.entry_write || cmd.age_write) begin
         age_mem[age_addr] <= clock_ff;
      end
      rd_key_ff   <= key_mem[idx_ff];
      rd_count_ff <= count_mem[idx_ff];
      rd_age_ff   <= age_mem[idx_ff];
   end

   // Request key, walk index and victim selection
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= req_start_value;
      end
      if (cmd.load_req || cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.fill_slot) begin
         victim_ff <= IDX_W'(filled_ff);
      end else if (cmd.slot_zero) begin
         victim_ff <= '0;
      end else if (cmd.div_take) begin
         victim_ff <= IDX_W'(rem_ff);
      end else if (cmd.lru_cmp && ((idx_ff == '0) || (rd_age_ff < oldest_ff))) begin
         victim_ff <= idx_ff;
      end
      if (cmd.lru_cmp && ((idx_ff == '0) || (rd_age_ff < oldest_ff))) begin
         oldest_ff <= rd_age_ff;
      end
   end

   // Collatz iteration, one step per cycle
   always_ff @(posedge clock) begin
      if (cmd.calc_start) begin
         n_ff         <= CALC_WIDTH'(key_ff);
         steps_ff     <= '0;
         sat_ff       <= 1'b0;
         calc_done_ff <= 1'b0;
      end else if (cmd.calc_step && !calc_done_ff) begin
         if (n_ff == CALC_WIDTH'(1)) begin
            calc_done_ff <= 1'b1;
         end else if (steps_ff == COUNT_MAX) begin
            calc_done_ff <= 1'b1;
            sat_ff       <= 1'b1;
         end else if (n_ff[0] && triple_ovf) begin
            calc_done_ff <= 1'b1;
            sat_ff       <= 1'b1;
            steps_ff     <= COUNT_MAX;
         end else begin
            n_ff     <= n_ff[0] ? triple_sum[CALC_WIDTH-1:0] : (n_ff >> 1);
            steps_ff <= steps_ff + COUNT_WIDTH'(1);
         end
      end
   end

   // Restoring remainder of the LFSR value by the way count
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff   <= lfsr_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_q_ff   <= {div_q_ff[LFSR_WIDTH-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
         if (rem_shift >= {1'b0, ways_eff_x}) begin
            rem_ff <= rem_shift - {1'b0, ways_eff_x};
         end else begin
            rem_ff <= rem_shift;
         end
      end
   end

   // Pending result, then the output register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         case (cmd.res_src)
            RES_HIT: begin
               res_count_ff <= rd_count_ff;
               res_hit_ff   <= 1'b1;
               res_sat_ff   <= 1'b0;
            end
            RES_CALC: begin
               res_count_ff <= steps_ff;
               res_hit_ff   <= 1'b0;
               res_sat_ff   <= sat_ff;
            end
            default: begin
               res_count_ff <= COUNT_MAX;
               res_hit_ff   <= 1'b0;
               res_sat_ff   <= 1'b1;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_count_ff <= res_count_ff;
         rsp_hit_ff   <= res_hit_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_count      = rsp_count_ff;
   assign rsp_was_hit         = rsp_hit_ff;
   assign rsp_count_saturated = rsp_sat_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_lfsr_alive: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("lfsr reached the all-zero lockup state");

   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_slot |-> (filled_ff < ways_eff))
      else $error("free slot taken with no room left");

   a_insert_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_write |-> (calc_done_ff && !sat_ff))
      else $error("insert of an unfinished or saturated count");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before it was taken");

endmodule

FILE: rtl/cmc_controller.sv
// ----------------------------------------------------------------------------
// cmc_controller: request sequencer for the Collatz memo cache
// Walks lookup, compute, victim choice, insert and response, as each needs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cmc_pkg::cmc_status_type status,
   output cmc_pkg::cmc_cmd_type    cmd
);
   import cmc_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOKUP = 4'd1;
   localparam logic [3:0] S_SRD    = 4'd2;
   localparam logic [3:0] S_SCMP   = 4'd3;
   localparam logic [3:0] S_CALC   = 4'd4;
   localparam logic [3:0] S_LRD    = 4'd5;
   localparam logic [3:0] S_LCMP   = 4'd6;
   localparam logic [3:0] S_DIVI   = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_WRITE  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (status.req_key_zero) begin
                  cmd.res_load = 1'b1;
                  cmd.res_src  = RES_ZERO;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            if (status.filled_zero) begin
               cmd.calc_start = 1'b1;
               state_in       = S_CALC;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (status.key_match) begin
               cmd.age_write = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_src   = RES_HIT;
               state_in      = S_DONE;
            end else if (status.search_last) begin
               cmd.calc_start = 1'b1;
               state_in       = S_CALC;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRD;
            end
         end
         S_CALC: begin
            if (!status.calc_done) begin
               cmd.calc_step = 1'b1;
            end else if (status.calc_sat) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_CALC;
               state_in     = S_DONE;
            end else if (status.has_free) begin
               cmd.fill_slot = 1'b1;
               state_in      = S_WRITE;
            end else begin
               case (status.policy)
                  POLICY_LRU: begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_LRD;
                  end
                  POLICY_RANDOM: begin
                     cmd.lfsr_step = 1'b1;
                     state_in      = S_DIVI;
                  end
                  default: begin
                     cmd.slot_zero = 1'b1;
                     state_in      = S_WRITE;
                  end
               endcase
            end
         end
         S_LRD: begin
            state_in = S_LCMP;
         end
         S_LCMP: begin
            cmd.lru_cmp = 1'b1;
            if (status.lru_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_LRD;
            end
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_WRITE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.entry_write = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_src     = RES_CALC;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/collatz_memo_cache.sv
// A zero start value is answered without a lookup; a hit ends the search at its
// entry; a miss walks every filled entry, computes the steps and, unless they
// saturate, picks a victim (free slot or slot zero directly, LRU scan of the
// ways, or a random draw). One request in flight: the next is accepted once the
// response is registered. Synchronous reset clears the controller, fill count,
// access clock and response valid and resets LFSR, policy and way count; cache
// entries hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
// collatz_memo_cache: Collatz step counter with a fully associative memo cache
// Looks up each nonzero start value in a small cache, computes misses one step
// per cycle and stores unsaturated counts, evicting by LRU, random or fixed slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module collatz_memo_cache #(
   parameter int CAPACITY    = cmc_pkg::CAPACITY_DEFAULT,
   parameter int COUNT_WIDTH = cmc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cmc_req_if.sink                             req_chan,
   cmc_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [cmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cmc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import cmc_pkg::*;

   // Command and status bundles between sequencer and datapath
   cmc_cmd_type    cmd;
   cmc_status_type status;

   logic                   rsp_valid;
   logic [COUNT_WIDTH-1:0] rsp_step_count;
   logic                   rsp_was_hit;
   logic                   rsp_count_saturated;

   // Sequencer: owns the request handshake, drives one command set per cycle
   cmc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: cache memories, Collatz unit, victim logic, registers and
   // the response output register
   cmc_datapath #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_start_value     (req_chan.start_value),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_valid),
      .rsp_step_count      (rsp_step_count),
      .rsp_was_hit         (rsp_was_hit),
      .rsp_count_saturated (rsp_count_saturated)
   );

   // Drive the response channel straight from the output register
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.step_count      = rsp_step_count;
   assign rsp_chan.was_hit         = rsp_was_hit;
   assign rsp_chan.count_saturated = rsp_count_saturated;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Collatz memo cache
// Streams start values through the request channel in random bursts and
// predicts every response with a cycle-free model of the cache: the lookup,
// the step count, fills, LRU, random and fixed-slot replacement. It switches
// the replacement settings between phases once the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import cmc_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX    = '1;
   localparam logic [CALC_WIDTH-1:0]   TRIPLE_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF - 64'd1) / 64'd3;
   localparam logic [KEY_WIDTH-1:0]    KEY_MAX      = '1;
   // Policy code with no name in the package; the block treats it as slot zero
   localparam logic [POLICY_WIDTH-1:0] POLICY_SPARE = 2'd3;

   localparam int          RANDOM_PER_PHASE = 58;
   localparam int          RECENT_DEPTH     = 24;
   localparam int          IDLE_SETTLE      = 8;
   localparam int          END_SETTLE       = 20;
   localparam int          REPORT_CAP       = 50;
   // Worst case: every request a saturated miss plus gaps and stalls, over ~600
   // requests, then taken about four times over.
   localparam int unsigned CYCLE_LIMIT      = 12_000_000;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   start_value;
      logic [COUNT_WIDTH-1:0] step_count;
      logic                   was_hit;
      logic                   count_saturated;
   } step_answer_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_TOGGLE
   } rx_mode_type;

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index    = REG_POLICY;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata    = '0;

   cmc_req_if                             req_if ();
   cmc_rsp_if #(.COUNT_WIDTH(COUNT_WIDTH)) rsp_if ();

   always #5 clock = ~clock;

   collatz_memo_cache #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Hold every channel input at a known value before the first edge
   initial begin
      req_if.valid       = 1'b0;
      req_if.start_value = '0;
      rsp_if.ready       = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Cache predictor: its own copy of the entries, fill count, access clock,
   // LFSR and the two settings
   // -------------------------------------------------------------------------
   logic [KEY_WIDTH-1:0]    memo_keys   [CAPACITY];
   logic [COUNT_WIDTH-1:0]  memo_counts [CAPACITY];
   logic [AGE_WIDTH-1:0]    memo_ages   [CAPACITY];
   int unsigned             memo_filled  = 0;
   logic [AGE_WIDTH-1:0]    access_tick  = '0;
   logic [LFSR_WIDTH-1:0]   victim_lfsr  = LFSR_SEED;
   logic [POLICY_WIDTH-1:0] cfg_policy   = POLICY_LRU;
   logic [WAYS_WIDTH-1:0]   cfg_ways     = WAYS_RESET;

   step_answer_type      expected_answers [$];
   logic [KEY_WIDTH-1:0] queued_starts    [$];
   logic [KEY_WIDTH-1:0] recent_starts    [$];
   int unsigned          mismatch_count = 0;

   // Walk 3n+1 / n/2 down to one; saturate on the count cap or a 64-bit overflow
   function automatic void predict_steps(input  logic [KEY_WIDTH-1:0]   start,
                                         output logic [COUNT_WIDTH-1:0] steps,
                                         output logic                   saturated);
      logic [CALC_WIDTH-1:0] n;
      n         = CALC_WIDTH'(start);
      steps     = '0;
      saturated = 1'b0;
      while (n != 1) begin
         if (steps == COUNT_MAX) begin
            saturated = 1'b1;
            return;
         end
         if (n[0]) begin
            if (n > TRIPLE_LIMIT) begin
               saturated = 1'b1;
               steps     = COUNT_MAX;
               return;
            end
            n = n * 3 + 1;
         end else begin
            n = n >> 1;
         end
         steps++;
      end
   endfunction

   function automatic int unsigned victim_slot(input int unsigned ways);
      int unsigned          slot;
      logic [AGE_WIDTH-1:0] oldest;
      slot = 0;
      if (cfg_policy == POLICY_LRU) begin
         // Oldest age wins; strict compare keeps ties on the lowest index
         oldest = memo_ages[0];
         for (int i = 1; i < ways; i++) begin
            if (memo_ages[i] < oldest) begin
               oldest = memo_ages[i];
               slot   = i;
            end
         end
      end else if (cfg_policy == POLICY_RANDOM) begin
         // Taps 16,14,13,11, shifting right: advance once per random eviction
         victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                        victim_lfsr[LFSR_WIDTH-1:1]};
         slot = victim_lfsr % ways;
      end
      return slot;
   endfunction

   // Serve one accepted start value and update the predicted cache state
   function automatic step_answer_type memo_lookup(input logic [KEY_WIDTH-1:0] start);
      step_answer_type answer;
      int unsigned     ways;
      int unsigned     slot;
      answer.start_value = start;
      answer.was_hit     = 1'b0;

      // Zero never reaches one: flag it, touch nothing
      if (start == '0) begin
         answer.step_count      = COUNT_MAX;
         answer.count_saturated = 1'b1;
         return answer;
      end

      access_tick++;

      // Every filled entry can hit, even above a lowered way count
      for (int i = 0; i < memo_filled; i++) begin
         if (memo_keys[i] == start) begin
            memo_ages[i]           = access_tick;
            answer.step_count      = memo_counts[i];
            answer.was_hit         = 1'b1;
            answer.count_saturated = 1'b0;
            return answer;
         end
      end

      predict_steps(start, answer.step_count, answer.count_saturated);

      // A saturated count is never stored, so it is recomputed every time
      if (!answer.count_saturated) begin
         ways = (cfg_ways == 0) ? 1 : (cfg_ways > CAPACITY) ? CAPACITY : cfg_ways;
         if (memo_filled < ways) begin
            slot = memo_filled;
            memo_filled++;
         end else begin
            slot = victim_slot(ways);
         end
         memo_keys[slot]   = start;
         memo_counts[slot] = answer.step_count;
         memo_ages[slot]   = access_tick;
      end
      return answer;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: pull start values from the queue, send them in bursts of
   // random length with random gaps, predict each one on acceptance
   // -------------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_answers.push_back(memo_lookup(req_if.start_value));

         // Advance only when the slot is empty or the held request just went in
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (queued_starts.size() != 0) begin
               req_if.valid       <= 1'b1;
               req_if.start_value <= queued_starts.pop_front();
               if (burst_left != 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  // Close the burst; a third of the time run straight on
                  burst_left <= $urandom_range(0, 30);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: stall on a random ready pattern that is redrawn over time
   // -------------------------------------------------------------------------
   rx_mode_type rx_mode = RX_ALWAYS;
   int unsigned rx_span = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_span == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_span <= $urandom_range(16, 96);
         end else begin
            rx_span <= rx_span - 1;
         end
         case (rx_mode)
            RX_ALWAYS: begin
               rsp_if.ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
               rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_if.ready <= ~rsp_if.ready;
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: compare each accepted response with the oldest answer
   // -------------------------------------------------------------------------
   function automatic void report_mismatch(input string what, input logic [KEY_WIDTH-1:0] start,
                                           input int unsigned want, input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t ns: %s mismatch for start %0d: expected %0d, actual %0d",
                  $realtime, what, start, want, got);
   endfunction

   always @(posedge clock) begin : answer_check
      step_answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
               $display("%0t ns: unexpected response: expected none, actual count %0d",
                        $realtime, rsp_if.step_count);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_if.step_count !== want.step_count)
               report_mismatch("step_count", want.start_value, want.step_count,
                               rsp_if.step_count);
            if (rsp_if.was_hit !== want.was_hit)
               report_mismatch("was_hit", want.start_value, want.was_hit, rsp_if.was_hit);
            if (rsp_if.count_saturated !== want.count_saturated)
               report_mismatch("count_saturated", want.start_value, want.count_saturated,
                               rsp_if.count_saturated);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog
   // -------------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   // Draw a new start value: small, medium or full 31-bit
   function automatic logic [KEY_WIDTH-1:0] fresh_start_value();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 3))
         0:       return KEY_WIDTH'($urandom_range(1, 1000));
         1:       return KEY_WIDTH'($urandom_range(1, 1 << 20));
         default: return raw[KEY_WIDTH-1:0];
      endcase
   endfunction

   // Mostly revisit recent values so hits and evictions both happen often
   function automatic logic [KEY_WIDTH-1:0] random_start_value();
      logic [KEY_WIDTH-1:0] start;
      int unsigned          pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         start = '0;
      end else if (pick < 6) begin
         start = ($urandom_range(0, 1) == 0) ? KEY_MAX : KEY_WIDTH'(1);
      end else if (pick < 62 && recent_starts.size() != 0) begin
         start = recent_starts[$urandom_range(0, recent_starts.size() - 1)];
      end else begin
         start = fresh_start_value();
         recent_starts.push_back(start);
         if (recent_starts.size() > RECENT_DEPTH)
            void'(recent_starts.pop_front());
      end
      return start;
   endfunction

   // Hold until every queued request went in and every answer came back
   task automatic wait_drained();
      while (queued_starts.size() != 0 || req_if.valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges; the block is idle here
   task automatic write_settings(input logic [POLICY_WIDTH-1:0] policy,
                                 input logic [WAYS_WIDTH-1:0]   ways);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= REG_POLICY;
      csr_wdata    <= CSR_DATA_WIDTH'(policy);
      @(posedge clock);
      cfg_policy   = policy;
      csr_index    <= REG_WAYS;
      csr_wdata    <= CSR_DATA_WIDTH'(ways);
      @(posedge clock);
      cfg_ways     = ways;
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [POLICY_WIDTH-1:0] policy,
                            input logic [WAYS_WIDTH-1:0]   ways);
      write_settings(policy, ways);
      repeat (RANDOM_PER_PHASE) queued_starts.push_back(random_start_value());
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings: zero, one, the largest
      // value, long-running starts, repeats that must hit, and enough
      // distinct values to fill all sixteen entries and force LRU eviction
      queued_starts = '{
         KEY_WIDTH'(0), KEY_WIDTH'(1), KEY_WIDTH'(2), KEY_WIDTH'(3), KEY_WIDTH'(27),
         KEY_MAX, 31'h4000_0000, KEY_WIDTH'(1), KEY_WIDTH'(27), KEY_WIDTH'(0),
         KEY_WIDTH'(97), KEY_WIDTH'(871), KEY_WIDTH'(6171), KEY_WIDTH'(77031),
         KEY_WIDTH'(837799), KEY_WIDTH'(8400511), KEY_WIDTH'(63728127),
         KEY_WIDTH'(670617279), 31'h5555_5555, 31'h2AAA_AAAA, KEY_WIDTH'(9),
         KEY_WIDTH'(12345), KEY_WIDTH'(1), KEY_MAX
      };
      wait_drained();

      // Settings sweep: each phase drains before the next write
      run_phase(POLICY_LRU,    5'd1);
      run_phase(POLICY_RANDOM, 5'd16);
      run_phase(POLICY_SLOT0,  5'd5);
      run_phase(POLICY_SPARE,  5'd0);
      run_phase(POLICY_RANDOM, 5'd3);
      run_phase(POLICY_LRU,    5'd31);
      run_phase(POLICY_RANDOM, 5'd20);
      run_phase(POLICY_LRU,    5'd7);
      run_phase(POLICY_SLOT0,  5'd16);
      run_phase(POLICY_LRU,    5'd16);

      // Catch any stray response after the last expected one
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/cmc_pkg.sv
rtl/cmc_ifs.sv
rtl/cmc_datapath.sv
rtl/cmc_controller.sv
rtl/collatz_memo_cache.sv
tb/tb_top.sv
